// ===== rtl/i2c_register_access_master_core_assert.svh =====
// assertion helpers shared by the rtl files
`ifndef I2C_REGISTER_ACCESS_MASTER_CORE_ASSERT_SVH
`define I2C_REGISTER_ACCESS_MASTER_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define IRM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("irm assertion failed");

// next-cycle implication, off during reset
`define IRM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("irm assertion failed");

`endif

// ===== rtl/irm_pkg.sv =====
package irm_pkg;

	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 4;

	// command codes
	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_WRITE = 3'd1;
	localparam logic [2:0] OP_READ  = 3'd2;
	localparam logic [2:0] OP_SET   = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_DEV_ADDR    = 2'd0;
	localparam logic [1:0] REG_HALF_PERIOD = 2'd1;
	localparam logic [1:0] REG_ACK_TIMEOUT = 2'd2;

	localparam logic [6:0] DEV_ADDR_RST    = 7'd40;
	localparam logic [7:0] HALF_PERIOD_RST = 8'd10;
	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] reg_addr;
		logic [7:0] data_value;
		logic       sda_level;
	} cmd_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_fail;
		logic       cmd_rejected;
	} res_t;

	typedef struct packed {
		logic [6:0] device_address;
		logic [7:0] half_period_ticks;
		logic [7:0] ack_timeout_ticks;
	} cfg_t;

endpackage

// ===== rtl/irm_regs.sv =====
module irm_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [irm_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [irm_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [irm_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output irm_pkg::cfg_t                   cfg
);
	import irm_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address    <= DEV_ADDR_RST;
			cfg_q.half_period_ticks <= HALF_PERIOD_RST;
			cfg_q.ack_timeout_ticks <= ACK_TIMEOUT_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_DEV_ADDR:    cfg_q.device_address    <= pwdata[6:0];
				REG_HALF_PERIOD: cfg_q.half_period_ticks <= pwdata[7:0];
				REG_ACK_TIMEOUT: cfg_q.ack_timeout_ticks <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_DEV_ADDR:    prdata = {{(APB_DATA_W-7){1'b0}}, cfg_q.device_address};
			REG_HALF_PERIOD: prdata = {{(APB_DATA_W-8){1'b0}}, cfg_q.half_period_ticks};
			REG_ACK_TIMEOUT: prdata = {{(APB_DATA_W-8){1'b0}}, cfg_q.ack_timeout_ticks};
			default:         prdata = '0;
		endcase
	end

endmodule

// ===== rtl/irm_seq.sv =====
`include "i2c_register_access_master_core_assert.svh"

module irm_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step_en,
	input  irm_pkg::cmd_t  cmd,
	input  irm_pkg::cfg_t  cfg,
	output irm_pkg::res_t  res
);
	import irm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ST_A, ST_ST_B, ST_TX_LO, ST_TX_HI, ST_AK_LO, ST_AK_HI, ST_RX_LO,
		ST_RX_HI, ST_NK_LO, ST_NK_HI, ST_SP_A, ST_SP_B, ST_SP_C, ST_RS_LO
	} state_t;

	state_t     state_q, state_d, state_e;
	logic [3:0] bit_cnt_q, bit_cnt_d, bit_inc;
	logic [7:0] shift_q, shift_d, shift_rx;
	logic [7:0] hp_cnt_q, hp_cnt_d, hp_base, hp_lim, hp_step;
	logic [7:0] ack_cnt_q, ack_cnt_d, ack_inc, ack_lim;
	logic [7:0] held_reg_q, held_reg_d, held_reg_e;
	logic [7:0] held_opd_q, held_opd_d, held_opd_e;
	logic [2:0] held_cmd_q, held_cmd_d, held_cmd_e;
	logic [7:0] cap_q, cap_d, cap_e;
	logic [1:0] bus_q, bus_d;
	logic [2:0] step_q, step_d, step_e, step_inc;
	logic       fail_q, fail_d, fail_e;
	logic       is_cmd, start, phase_end, done, failed;
	logic [7:0] rd;

	always_comb begin
		is_cmd = cmd.op inside {OP_WRITE, OP_READ, OP_SET, OP_CLEAR};
		start  = (state_q == ST_IDLE) && is_cmd;

		// a command in idle loads its operands and enters start at once
		state_e    = start ? ST_ST_A : state_q;
		held_cmd_e = start ? cmd.op : held_cmd_q;
		held_reg_e = start ? cmd.reg_addr : held_reg_q;
		held_opd_e = start ? cmd.data_value : held_opd_q;
		cap_e      = start ? 8'd0 : cap_q;
		step_e     = start ? 3'd0 : step_q;
		fail_e     = start ? 1'b0 : fail_q;
		hp_base    = start ? 8'd0 : hp_cnt_q;

		// phase timing, zero half period acts as one
		hp_lim    = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
		phase_end = ({1'b0, hp_base} + 9'd1) >= {1'b0, hp_lim};
		hp_step   = phase_end ? 8'd0 : hp_base + 8'd1;

		ack_lim  = (cfg.ack_timeout_ticks == 8'd0) ? 8'd1 : cfg.ack_timeout_ticks;
		ack_inc  = ack_cnt_q + 8'd1;
		bit_inc  = bit_cnt_q + 4'd1;
		step_inc = step_e + 3'd1;
		shift_rx = {shift_q[6:0], cmd.sda_level};

		state_d    = state_e;
		bit_cnt_d  = bit_cnt_q;
		shift_d    = shift_q;
		hp_cnt_d   = hp_base;
		ack_cnt_d  = ack_cnt_q;
		held_reg_d = held_reg_e;
		held_opd_d = held_opd_e;
		held_cmd_d = held_cmd_e;
		cap_d      = cap_e;
		bus_d      = bus_q;
		step_d     = step_e;
		fail_d     = fail_e;
		done       = 1'b0;
		failed     = 1'b0;
		rd         = 8'd0;

		unique case (state_e)
			ST_ST_A: begin
				bus_d    = 2'b11;
				hp_cnt_d = hp_step;
				if (phase_end) state_d = ST_ST_B;
			end
			ST_ST_B: begin
				bus_d    = 2'b10;
				hp_cnt_d = hp_step;
				if (phase_end) begin
					shift_d   = {cfg.device_address, (step_e != 3'd0)};
					bit_cnt_d = 4'd0;
					state_d   = ST_TX_LO;
				end
			end
			ST_TX_LO: begin
				bus_d    = {1'b0, shift_q[7]};
				hp_cnt_d = hp_step;
				if (phase_end) state_d = ST_TX_HI;
			end
			ST_TX_HI: begin
				bus_d    = {1'b1, shift_q[7]};
				hp_cnt_d = hp_step;
				if (phase_end) begin
					shift_d   = {shift_q[6:0], 1'b0};
					bit_cnt_d = bit_inc;
					if (bit_inc >= BITS_PER_BYTE) begin
						ack_cnt_d = 8'd0;
						state_d   = ST_AK_LO;
					end else begin
						state_d = ST_TX_LO;
					end
				end
			end
			ST_AK_LO, ST_RX_LO, ST_NK_LO: begin
				bus_d    = 2'b01;
				hp_cnt_d = hp_step;
				if (phase_end) begin
					unique case (state_e)
						ST_AK_LO: state_d = ST_AK_HI;
						ST_RX_LO: state_d = ST_RX_HI;
						default:  state_d = ST_NK_HI;
					endcase
				end
			end
			ST_AK_HI: begin
				bus_d    = 2'b11;
				hp_cnt_d = 8'd0;
				if (!cmd.sda_level) begin
					step_d = step_inc;
					if (step_inc == 3'd1) begin
						shift_d   = held_reg_e;
						bit_cnt_d = 4'd0;
						state_d   = ST_TX_LO;
					end else if (held_cmd_e == OP_WRITE) begin
						if (step_inc == 3'd2) begin
							shift_d   = held_opd_e;
							bit_cnt_d = 4'd0;
							state_d   = ST_TX_LO;
						end else begin
							state_d = ST_SP_A;
						end
					end else if (step_inc == 3'd2) begin
						state_d = ST_RS_LO;
					end else begin
						shift_d   = 8'd0;
						bit_cnt_d = 4'd0;
						state_d   = ST_RX_LO;
					end
				end else begin
					ack_cnt_d = ack_inc;
					if (ack_inc >= ack_lim) begin
						fail_d  = 1'b1;
						state_d = ST_SP_A;
					end
				end
			end
			ST_RX_HI: begin
				bus_d    = 2'b11;
				hp_cnt_d = hp_step;
				if (phase_end) begin
					shift_d   = shift_rx;
					bit_cnt_d = bit_inc;
					if (bit_inc >= BITS_PER_BYTE) begin
						cap_d   = shift_rx;
						state_d = ST_NK_LO;
					end else begin
						state_d = ST_RX_LO;
					end
				end
			end
			ST_NK_HI: begin
				bus_d    = 2'b11;
				hp_cnt_d = hp_step;
				if (phase_end) state_d = ST_SP_A;
			end
			ST_SP_A: begin
				bus_d    = 2'b00;
				hp_cnt_d = hp_step;
				if (phase_end) state_d = ST_SP_B;
			end
			ST_SP_B: begin
				bus_d    = 2'b10;
				hp_cnt_d = hp_step;
				if (phase_end) state_d = ST_SP_C;
			end
			ST_SP_C: begin
				bus_d    = 2'b11;
				hp_cnt_d = hp_step;
				if (phase_end) begin
					if (!fail_e && (held_cmd_e == OP_SET || held_cmd_e == OP_CLEAR)) begin
						// read half done, go on with the write half
						held_opd_d = (held_cmd_e == OP_SET) ? (cap_e | held_opd_e)
						                                    : (cap_e & ~held_opd_e);
						held_cmd_d = OP_WRITE;
						step_d     = 3'd0;
						state_d    = ST_ST_A;
					end else begin
						done    = 1'b1;
						failed  = fail_e;
						rd      = fail_e ? 8'd0 : cap_e;
						state_d = ST_IDLE;
					end
				end
			end
			ST_RS_LO: begin
				bus_d    = 2'b01;
				hp_cnt_d = hp_step;
				if (phase_end) state_d = ST_ST_A;
			end
			default: begin
				bus_d   = 2'b11;
				state_d = ST_IDLE;
			end
		endcase

		res.scl_level    = bus_d[1];
		res.sda_release  = bus_d[0];
		res.busy_res     = (state_d != ST_IDLE);
		res.done_res     = done;
		res.read_data    = rd;
		res.ack_fail     = failed;
		res.cmd_rejected = is_cmd && (state_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			bit_cnt_q  <= 4'd0;
			shift_q    <= 8'd0;
			hp_cnt_q   <= 8'd0;
			ack_cnt_q  <= 8'd0;
			held_reg_q <= 8'd0;
			held_opd_q <= 8'd0;
			held_cmd_q <= OP_TICK;
			cap_q      <= 8'd0;
			bus_q      <= 2'b11;
			step_q     <= 3'd0;
			fail_q     <= 1'b0;
		end else if (step_en) begin
			state_q    <= state_d;
			bit_cnt_q  <= bit_cnt_d;
			shift_q    <= shift_d;
			hp_cnt_q   <= hp_cnt_d;
			ack_cnt_q  <= ack_cnt_d;
			held_reg_q <= held_reg_d;
			held_opd_q <= held_opd_d;
			held_cmd_q <= held_cmd_d;
			cap_q      <= cap_d;
			bus_q      <= bus_d;
			step_q     <= step_d;
			fail_q     <= fail_d;
		end
	end

	`IRM_ASSERT_IMP(a_idle_bus_released, clk, arst_n, state_q == ST_IDLE, bus_q == 2'b11)
	`IRM_ASSERT_IMP(a_fail_only_in_stop, clk, arst_n, fail_q && state_q != ST_IDLE, state_q == ST_SP_A || state_q == ST_SP_B || state_q == ST_SP_C)
	`IRM_ASSERT_IMP(a_bit_cnt_bound, clk, arst_n, 1'b1, bit_cnt_q <= BITS_PER_BYTE)

endmodule

// ===== rtl/i2c_register_access_master_core.sv =====
// I2C master for one-byte register transactions (write, read, set bits, clear bits).
// Each transaction on the cmd channel is one bus tick: it carries the sampled SDA level
// and optionally a command, and yields exactly one transaction on the res channel with
// the SCL/SDA levels to drive for that tick plus busy, done, read data, ack failure and
// command-rejected flags. Throughput is one tick per clock when not stalled; each tick
// passes the input then the result register; the sequencer steps once per tick between
// them. Set and clear run a read followed by a write of the modified value. A command
// that arrives while busy is dropped and flagged. Configuration goes through a small
// APB port (device address at 0x0, half period ticks at 0x4, ack timeout ticks at 0x8)
// and must only be written while the core is idle.

`include "i2c_register_access_master_core_assert.svh"

module i2c_register_access_master_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// tick / command channel
	input  logic                            cmd_valid,
	output logic                            cmd_stall,
	input  irm_pkg::cmd_t                   cmd,
	// per-tick result channel
	output logic                            res_valid,
	input  logic                            res_stall,
	output irm_pkg::res_t                   res,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [irm_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [irm_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [irm_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import irm_pkg::*;

	cfg_t cfg;
	cmd_t cmd_s1;
	logic cmd_valid_s1;
	res_t res_s2, res_next;
	logic res_valid_s2;
	logic advance;
	logic cmd_accept;

	// config registers
	irm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// the held tick moves on whenever the result register is free or being drained
	assign advance    = cmd_valid_s1 && (!res_valid_s2 || !res_stall);
	assign cmd_stall  = cmd_valid_s1 && !advance;
	assign cmd_accept = cmd_valid && !cmd_stall;

	// bus sequencer, steps on the tick held in the input register
	irm_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.cmd     (cmd_s1),
		.cfg     (cfg),
		.res     (res_next)
	);

	// input register valid and result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (cmd_accept) begin
				cmd_valid_s1 <= 1'b1;
			end else if (advance) begin
				cmd_valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_s2 <= 1'b1;
			end else if (!res_stall) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			cmd_s1 <= cmd;
		end
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign res_valid = res_valid_s2;
	assign res       = res_s2;

	`IRM_ASSERT_IMP(a_stall_only_when_blocked, clk, arst_n, cmd_stall, res_valid_s2 && res_stall)
	`IRM_ASSERT_NXT(a_blocked_tick_kept, clk, arst_n, cmd_valid_s1 && !advance, cmd_valid_s1)
	`IRM_ASSERT_IMP(a_done_not_busy, clk, arst_n, res_valid_s2 && res_s2.done_res, !res_s2.busy_res)
	`IRM_ASSERT_IMP(a_fail_with_done, clk, arst_n, res_valid_s2 && res_s2.ack_fail, res_s2.done_res)

endmodule
